// File: rtl/core/mcpr_pkg.sv
// ----------------------------------------------------------------------------
// mcpr_pkg: shared definitions for the PWM ramp controller
// Field widths, channel count, command and register codes, level clamp.
// ----------------------------------------------------------------------------
package mcpr_pkg;

  // Channel count and the derived index width
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int REPORT_MAX   = 4;
  localparam int REPORT_N     = (NUM_CHANNELS < REPORT_MAX) ? NUM_CHANNELS : REPORT_MAX;

  // Field widths
  localparam int MODE_W     = 4;
  localparam int CHAN_W     = 2;
  localparam int LVL_W      = 16;
  localparam int TEMP_W     = 10;
  localparam int TIME_W     = 32;
  localparam int PROD_W     = 2 * LVL_W;
  localparam int STEP_CNT_W = $clog2(LVL_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LVL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_TEMP = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_TEMP = CFG_IDX_W'(3);

  localparam logic [LVL_W-1:0]  MIN_LEVEL_RST = '0;
  localparam logic [LVL_W-1:0]  MAX_LEVEL_RST = '1;
  localparam logic [TEMP_W-1:0] WARN_TEMP_RST = TEMP_W'(70);
  localparam logic [TEMP_W-1:0] CRIT_TEMP_RST = TEMP_W'(90);

  // Command codes
  localparam logic [MODE_W-1:0] MODE_SET      = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_RAMP     = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_TEMP     = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_ENABLE   = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_DISABLE  = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_STOP     = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_STOP_ALL = MODE_W'(6);
  localparam logic [MODE_W-1:0] MODE_CLEAR    = MODE_W'(7);
  localparam logic [MODE_W-1:0] MODE_TICK     = MODE_W'(8);

  // Below the minimum goes to zero; the low test wins over the high one
  function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] v,
                                                   input logic [LVL_W-1:0] lo,
                                                   input logic [LVL_W-1:0] hi);
    logic [LVL_W-1:0] r;
    if (v < lo) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/mcpr_mul.sv
// ----------------------------------------------------------------------------
// mcpr_mul: bit-serial unsigned multiplier
// Shift-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mcpr_mul
  import mcpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [LVL_W-1:0]  mcand,
  input  logic [LVL_W-1:0]  mplier,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic                  busy;
  logic [STEP_CNT_W-1:0] cnt;
  logic [LVL_W-1:0]      mc;
  logic [LVL_W-1:0]      hi;
  logic [LVL_W-1:0]      lo;
  logic [LVL_W:0]        sum;

  // add the multiplicand when the low bit is set
  assign sum  = lo[0] ? ({1'b0, hi} + {1'b0, mc}) : {1'b0, hi};
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mc   <= mcand;
        hi   <= '0;
        lo   <= mplier;
      end else if (busy) begin
        hi  <= sum[LVL_W:1];
        lo  <= {sum[0], lo[LVL_W-1:1]};
        cnt <= STEP_CNT_W'(cnt + 1'b1);
        if (cnt == STEP_CNT_W'(LVL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/mcpr_div.sv
// ----------------------------------------------------------------------------
// mcpr_div: bit-serial restoring divider
// One quotient bit per cycle; dividend high half must be below the divisor.
// ----------------------------------------------------------------------------
module mcpr_div
  import mcpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [LVL_W-1:0]  divisor,
  output logic              done,
  output logic [LVL_W-1:0]  quot
);

  logic                  busy;
  logic [STEP_CNT_W-1:0] cnt;
  logic [LVL_W-1:0]      dv;
  logic [LVL_W-1:0]      rem;
  logic [LVL_W:0]        trial;
  logic [LVL_W:0]        diff;
  logic                  fits;

  assign trial = {rem, quot[LVL_W-1]};
  assign diff  = trial - {1'b0, dv};
  assign fits  = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dv   <= divisor;
        rem  <= dividend[PROD_W-1:LVL_W];
        quot <= dividend[LVL_W-1:0];
      end else if (busy) begin
        // keep the difference only when the divisor fits
        rem  <= fits ? diff[LVL_W-1:0] : trial[LVL_W-1:0];
        quot <= {quot[LVL_W-2:0], fits};
        cnt  <= STEP_CNT_W'(cnt + 1'b1);
        if (cnt == STEP_CNT_W'(LVL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/multi_channel_pwm_ramp_controller.sv
// A single-channel request is applied when accepted; its result is then loaded into the output
// register once that register is free. A tick walks every channel; a ramping channel is
// checked, then passes through the serial multiplier and the divider, others only the check;
// then 4 results leave one per cycle while out_stall allows. One request is handled at a time.
// Reset: levels 0, channels enabled, flags and ramps cleared, registers to defaults.
// ----------------------------------------------------------------------------
// multi_channel_pwm_ramp_controller: per-channel PWM levels with timed ramps
// Handles set/ramp/temperature/enable/disable/stop/stop-all/clear/tick
// requests, clamps levels against the min/max registers and reports the
// resulting channel state on a registered output.
// ----------------------------------------------------------------------------
module multi_channel_pwm_ramp_controller
  import mcpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     mode,
  input  logic [CHAN_W-1:0]     chan,
  input  logic [LVL_W-1:0]      level,
  input  logic [LVL_W-1:0]      ramp_ms,
  input  logic [TEMP_W-1:0]     temp_c,
  input  logic [TIME_W-1:0]     now_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAN_W-1:0]     out_chan,
  output logic [LVL_W-1:0]      out_level,
  output logic                  is_on,
  output logic                  overheat,
  output logic                  ramping,
  output logic                  accepted,
  output logic                  last_one
);

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a request
    S_TCHK,   // tick: inspect one channel's ramp
    S_TMUL,   // tick: wait for |diff| * elapsed
    S_TDIV,   // tick: wait for product / length
    S_EMIT    // push results into the output register
  } state_t;

  state_t state;

  // Configuration registers
  logic [LVL_W-1:0]  min_lvl;
  logic [LVL_W-1:0]  max_lvl;
  logic [TEMP_W-1:0] warn_temp;
  logic [TEMP_W-1:0] crit_temp;

  // Per-channel state
  logic [LVL_W-1:0]        drive     [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] chan_en;
  logic [NUM_CHANNELS-1:0] heat;
  logic [NUM_CHANNELS-1:0] ramp_on;
  logic [LVL_W-1:0]        ramp_goal [NUM_CHANNELS];
  logic [LVL_W-1:0]        ramp_start[NUM_CHANNELS];
  logic [TIME_W-1:0]       ramp_t0   [NUM_CHANNELS];
  logic [LVL_W-1:0]        ramp_len  [NUM_CHANNELS];

  // Request context held while the request is worked on
  logic [CH_W-1:0]   cur_ch;
  logic [TIME_W-1:0] now_q;
  logic [CHAN_W-1:0] rep_chan;
  logic              rep_multi;
  logic              rep_tick;
  logic              rep_blank;
  logic              rep_acc;

  // Read port into the channel state
  logic [CH_W-1:0]   cidx;
  logic [CH_W-1:0]   rd_ch;
  logic              chan_bad;
  logic [LVL_W-1:0]  r_drive;
  logic              r_en;
  logic              r_heat;
  logic              r_ramp;
  logic [LVL_W-1:0]  r_goal;
  logic [LVL_W-1:0]  r_start;
  logic [TIME_W-1:0] r_t0;
  logic [LVL_W-1:0]  r_len;

  // Tick datapath
  logic [TIME_W-1:0] elapsed;
  logic              ramp_done;
  logic              tick_live;
  logic              dir_neg;
  logic [LVL_W-1:0]  mag;
  logic [LVL_W-1:0]  interp;
  logic              mul_start;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic              div_start;
  logic              div_done;
  logic [LVL_W-1:0]  div_quot;

  logic [LVL_W-1:0]  goal_in;
  logic              last_ch;
  logic              last_rep;
  logic              in_acc;
  logic              emit_go;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      min_lvl   <= MIN_LEVEL_RST;
      max_lvl   <= MAX_LEVEL_RST;
      warn_temp <= WARN_TEMP_RST;
      crit_temp <= CRIT_TEMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_LEVEL: min_lvl   <= cfg_data;
        CFG_MAX_LEVEL: max_lvl   <= cfg_data;
        CFG_WARN_TEMP: warn_temp <= cfg_data[TEMP_W-1:0];
        CFG_CRIT_TEMP: crit_temp <= cfg_data[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Channel read port: the addressed channel while idle, the walk index after
  // --------------------------------------------------------------------------
  assign cidx     = CH_W'(chan);
  assign chan_bad = 32'(chan) >= 32'(NUM_CHANNELS);
  assign rd_ch    = (state == S_IDLE) ? cidx : cur_ch;

  assign r_drive = drive[rd_ch];
  assign r_en    = chan_en[rd_ch];
  assign r_heat  = heat[rd_ch];
  assign r_ramp  = ramp_on[rd_ch];
  assign r_goal  = ramp_goal[rd_ch];
  assign r_start = ramp_start[rd_ch];
  assign r_t0    = ramp_t0[rd_ch];
  assign r_len   = ramp_len[rd_ch];

  assign goal_in = clamp_level(level, min_lvl, max_lvl);

  // --------------------------------------------------------------------------
  // Tick datapath: level = start +/- (|goal - start| * elapsed) / length.
  // Magnitudes keep the truncation toward zero; the result always lies
  // between the start and goal levels and is then clamped to the min/max registers.
  // --------------------------------------------------------------------------
  assign elapsed   = now_q - r_t0;
  assign ramp_done = elapsed >= TIME_W'(r_len);
  assign tick_live = r_ramp && r_en;
  assign dir_neg   = r_goal < r_start;
  assign mag       = dir_neg ? (r_start - r_goal) : (r_goal - r_start);
  assign interp    = dir_neg ? (r_start - div_quot) : (r_start + div_quot);

  assign mul_start = (state == S_TCHK) && tick_live && !ramp_done;
  assign div_start = (state == S_TMUL) && mul_done;

  mcpr_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mag),
    .mplier (elapsed[LVL_W-1:0]),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  mcpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (r_len),
    .done     (div_done),
    .quot     (div_quot)
  );

  assign last_ch  = cur_ch == CH_W'(NUM_CHANNELS - 1);
  assign last_rep = cur_ch == CH_W'(REPORT_N - 1);

  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // Sequencer: apply the request, walk channels on a tick, emit results
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      chan_en   <= '1;
      heat      <= '0;
      ramp_on   <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        drive[i] <= '0;
      end
    end else begin
      // drop the result once taken; a new load below overrides
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            rep_chan  <= chan;
            rep_multi <= 1'b0;
            rep_tick  <= 1'b0;
            rep_blank <= 1'b0;
            rep_acc   <= 1'b1;
            cur_ch    <= cidx;
            state     <= S_EMIT;
            if (mode == MODE_STOP_ALL) begin
              // cancel every ramp, zero enabled channels
              rep_multi <= 1'b1;
              cur_ch    <= '0;
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                ramp_on[i] <= 1'b0;
                if (chan_en[i]) begin
                  drive[i] <= '0;
                end
              end
            end else if (mode == MODE_TICK) begin
              rep_multi <= 1'b1;
              rep_tick  <= 1'b1;
              cur_ch    <= '0;
              now_q     <= now_ms;
              state     <= S_TCHK;
            end else if (chan_bad) begin
              // nonexistent channel: blank result, no change
              rep_blank <= 1'b1;
            end else begin
              unique case (mode)
                MODE_SET: begin
                  if (!r_en) begin
                    rep_acc <= 1'b0;
                  end else begin
                    drive[cidx]   <= goal_in;
                    ramp_on[cidx] <= 1'b0;
                  end
                end
                MODE_RAMP: begin
                  if (!r_en) begin
                    rep_acc <= 1'b0;
                  end else if (ramp_ms == '0 || goal_in == r_drive) begin
                    // immediate: acts as set
                    drive[cidx]   <= goal_in;
                    ramp_on[cidx] <= 1'b0;
                  end else begin
                    ramp_on[cidx]    <= 1'b1;
                    ramp_goal[cidx]  <= goal_in;
                    ramp_start[cidx] <= r_drive;
                    ramp_t0[cidx]    <= now_ms;
                    ramp_len[cidx]   <= ramp_ms;
                  end
                end
                MODE_TEMP: begin
                  if (temp_c >= crit_temp) begin
                    // critical: flag, stop, reject
                    heat[cidx]    <= 1'b1;
                    ramp_on[cidx] <= 1'b0;
                    rep_acc       <= 1'b0;
                    if (r_en) begin
                      drive[cidx] <= '0;
                    end
                  end else begin
                    heat[cidx] <= temp_c >= warn_temp;
                  end
                end
                MODE_ENABLE: begin
                  chan_en[cidx] <= 1'b1;
                end
                MODE_DISABLE: begin
                  ramp_on[cidx] <= 1'b0;
                  chan_en[cidx] <= 1'b0;
                  if (r_en) begin
                    drive[cidx] <= '0;
                  end
                end
                MODE_STOP: begin
                  ramp_on[cidx] <= 1'b0;
                  rep_acc       <= r_en;
                  if (r_en) begin
                    drive[cidx] <= '0;
                  end
                end
                MODE_CLEAR: begin
                  heat[cidx] <= 1'b0;
                end
                default: begin
                  // unknown command: report state, reject
                  rep_acc <= 1'b0;
                end
              endcase
            end
          end
        end

        S_TCHK: begin
          if (!tick_live) begin
            if (last_ch) begin
              cur_ch <= '0;
              state  <= S_EMIT;
            end else begin
              cur_ch <= CH_W'(cur_ch + 1'b1);
            end
          end else if (ramp_done) begin
            // ramp time reached: land on the goal, clamped by current limits
            drive[cur_ch]   <= clamp_level(r_goal, min_lvl, max_lvl);
            ramp_on[cur_ch] <= 1'b0;
            if (last_ch) begin
              cur_ch <= '0;
              state  <= S_EMIT;
            end else begin
              cur_ch <= CH_W'(cur_ch + 1'b1);
            end
          end else begin
            state <= S_TMUL;
          end
        end

        S_TMUL: begin
          if (mul_done) begin
            state <= S_TDIV;
          end
        end

        S_TDIV: begin
          if (div_done) begin
            drive[cur_ch] <= clamp_level(interp, min_lvl, max_lvl);
            if (last_ch) begin
              cur_ch <= '0;
              state  <= S_EMIT;
            end else begin
              cur_ch <= CH_W'(cur_ch + 1'b1);
              state  <= S_TCHK;
            end
          end
        end

        S_EMIT: begin
          if (emit_go) begin
            out_valid <= 1'b1;
            out_chan  <= rep_multi ? CHAN_W'(cur_ch) : rep_chan;
            out_level <= rep_blank ? '0 : r_drive;
            is_on     <= !rep_blank && r_en;
            overheat  <= !rep_blank && r_heat;
            ramping   <= !rep_blank && r_ramp;
            if (rep_blank) begin
              accepted <= 1'b0;
            end else if (rep_multi) begin
              accepted <= rep_tick || r_en;
            end else begin
              accepted <= rep_acc;
            end
            last_one <= !rep_multi || last_rep;
            if (rep_multi && !last_rep) begin
              cur_ch <= CH_W'(cur_ch + 1'b1);
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // serial units only finish while the sequencer waits on them
  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_TMUL)
    else $error("multiplier finished outside its wait state");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_TDIV)
    else $error("divider finished outside its wait state");

  // a live ramp never divides by a zero length
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> r_len != '0)
    else $error("ramp division started with zero length");

  // the interpolation step never exceeds the ramp span
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TDIV && div_done) |-> div_quot <= mag)
    else $error("interpolation step beyond ramp span");

endmodule
